// ===== hw/rtl/rcan_pkg.sv =====
// ----------------------------------------------------------------------------
// rcan_pkg
// Shared types and fixed constants for the circle raster canvas: command,
// shape and status codes, register indexes, field widths, stream offsets.
// ----------------------------------------------------------------------------
package rcan_pkg;

  // Field widths fixed by the stream format
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 20;
  localparam int CHAR_W   = 8;
  localparam int PIXIDX_W = 9;
  localparam int CFG_W    = 10;
  localparam int CFGIDX_W = 2;
  localparam int STATUS_W = 2;

  // Radius arithmetic: r - one needs one extra bit, squares double it
  localparam int INNER_W  = COORD_W + 1;
  localparam int RSQ_W    = 2 * INNER_W;

  // Input tdata layout, lowest bit first
  localparam int IN_CX_LSB    = 0;
  localparam int IN_CY_LSB    = IN_CX_LSB + COORD_W;
  localparam int IN_R_LSB     = IN_CY_LSB + COORD_W;
  localparam int IN_SHAPE_LSB = IN_R_LSB + COORD_W;
  localparam int IN_PAINT_LSB = IN_SHAPE_LSB + CHAR_W;
  localparam int IN_COL_LSB   = IN_PAINT_LSB + CHAR_W;
  localparam int IN_ROW_LSB   = IN_COL_LSB + PIXIDX_W;
  localparam int IN_USED_W    = IN_ROW_LSB + PIXIDX_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout
  localparam int OUT_USED_W  = STATUS_W + CHAR_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Shape type bytes
  localparam logic [CHAR_W-1:0] SHAPE_FILLED = 8'h43;
  localparam logic [CHAR_W-1:0] SHAPE_RING   = 8'h63;

  // Result status
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CIR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

  // Register indexes
  localparam logic [CFGIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFGIDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFGIDX_W-1:0] REG_BGCHAR = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0]  RST_WIDTH  = 10'd300;
  localparam logic [CFG_W-1:0]  RST_HEIGHT = 10'd300;
  localparam logic [CHAR_W-1:0] RST_BGCHAR = 8'd32;

  // Sweep request from the controller
  typedef struct packed {
    logic                      start;
    logic                      clear_mode;
    logic                      ring;
    logic                      ring_all;
    logic [CHAR_W-1:0]         fill_char;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RSQ_W-1:0]          rsq;
    logic [RSQ_W-1:0]          inner_sq;
  } sweep_cmd_t;

  // Sweep progress back to the controller
  typedef struct packed {
    logic running;
    logic done;
  } sweep_stat_t;

endpackage

// ===== hw/rtl/rcan_mem.sv =====
// ----------------------------------------------------------------------------
// rcan_mem
// Canvas store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcan_mem #(
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];

  // Write one pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one pixel, data valid the following cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/rcan_sweep.sv =====
// ----------------------------------------------------------------------------
// rcan_sweep
// Raster walker: steps over every pixel in use, one per cycle, computes the
// squared distance to the circle center in a short pipeline and writes the
// pixels that the clear or the circle covers.
// ----------------------------------------------------------------------------
module rcan_sweep #(
  parameter int FRAC_BITS = 8,
  parameter int IDX_W     = 9,
  parameter int CMP_W     = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rcan_pkg::sweep_cmd_t    cmd,
  input  logic [CMP_W-1:0]        width_eff,
  input  logic [CMP_W-1:0]        height_eff,
  output rcan_pkg::sweep_stat_t   stat,
  output logic                    wr_en,
  output logic [2*IDX_W-1:0]      wr_addr,
  output logic [7:0]              wr_data
);
  import rcan_pkg::*;

  localparam int OFF_W = IDX_W + FRAC_BITS + 1;
  localparam int DX_W  = ((OFF_W > COORD_W) ? OFF_W : COORD_W) + 1;
  localparam int SQ_W  = 2 * DX_W;
  localparam int D2_W  = SQ_W + 1;

  logic             running;
  logic             active;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic             col_last;
  logic             row_last;

  logic                   v1;
  logic [IDX_W-1:0]       row1;
  logic [IDX_W-1:0]       col1;
  logic signed [DX_W-1:0] dx1;
  logic signed [DX_W-1:0] dy1;

  logic                   v2;
  logic [IDX_W-1:0]       row2;
  logic [IDX_W-1:0]       col2;
  logic [SQ_W-1:0]        sqx;
  logic [SQ_W-1:0]        sqy;

  logic signed [SQ_W-1:0] dx_wide;
  logic signed [SQ_W-1:0] dy_wide;
  logic [D2_W-1:0]        d2;
  logic                   in_disc;
  logic                   in_ring;
  logic                   done;

  assign col_last = (CMP_W'(col) == (width_eff - CMP_W'(1)));
  assign row_last = (CMP_W'(row) == (height_eff - CMP_W'(1)));

  // Finished once the walker stopped and the pipeline drained
  assign done = running && !active && !v1 && !v2;
  assign stat.running = running;
  assign stat.done    = done;

  // Walk rows and columns of the canvas in use
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      active  <= 1'b0;
    end else if (cmd.start) begin
      running <= 1'b1;
      active  <= (width_eff != '0) && (height_eff != '0);
    end else begin
      if (done) begin
        running <= 1'b0;
      end
      if (active && col_last && row_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row <= '0;
      col <= '0;
    end else if (active) begin
      if (col_last) begin
        col <= '0;
        row <= row + IDX_W'(1);
      end else begin
        col <= col + IDX_W'(1);
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= active;
      v2 <= v1;
    end
  end

  // Stage 1: offsets from the center
  always_ff @(posedge clk) begin
    row1 <= row;
    col1 <= col;
    dx1  <= DX_W'(cmd.cx) - (DX_W'(col) << FRAC_BITS);
    dy1  <= DX_W'(cmd.cy) - (DX_W'(row) << FRAC_BITS);
  end

  // Stage 2: squares
  assign dx_wide = SQ_W'(dx1);
  assign dy_wide = SQ_W'(dy1);

  always_ff @(posedge clk) begin
    row2 <= row1;
    col2 <= col1;
    sqx  <= $unsigned(dx_wide * dx_wide);
    sqy  <= $unsigned(dy_wide * dy_wide);
  end

  // Stage 3: compare with the radius bounds and write
  assign d2      = D2_W'(sqx) + D2_W'(sqy);
  assign in_disc = (d2 <= D2_W'(cmd.rsq));
  assign in_ring = cmd.ring_all || (d2 > D2_W'(cmd.inner_sq));

  assign wr_en   = v2 && (cmd.clear_mode || (in_disc && (!cmd.ring || in_ring)));
  assign wr_addr = {row2, col2};
  assign wr_data = cmd.fill_char;

`ifndef SYNTHESIS
  a_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> running)
    else $error("canvas write outside a sweep");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !running)
    else $error("sweep started while another runs");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |=> !running && !wr_en)
    else $error("sweep kept running after done");
`endif

endmodule

// ===== hw/rtl/circle_raster_canvas.sv =====
// ----------------------------------------------------------------------------
// circle_raster_canvas
// Character canvas with clear, circle draw and pixel read commands.
//
//   channel   dir   transaction carries
//   s_axis    in    command (tuser), circle and read fields (tdata)
//   m_axis    out   status and pixel character (tdata)
//   cfg       in    register index and write data
//
// A clear or a draw steps over the canvas in use one pixel per cycle through
// the canvas write port; bad circles, reads and unused command codes skip the sweep.
// Reset returns control to idle and the registers to their reset values; the
// canvas holds garbage until cleared.
// The result register lets the next command enter while a result waits;
// a finished command holds until that register is free.
// ----------------------------------------------------------------------------
module circle_raster_canvas #(
  parameter int MAX_SIDE  = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // pixel_row, pixel_col, paint_char, shape_type, radius, center_y, center_x
  // from the top down; center_x in the lowest bits
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [rcan_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // command
  input  logic [rcan_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status [1:0], pixel_char [9:2]
  output logic [rcan_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rcan_pkg::CFGIDX_W-1:0]        cfg_index,
  input  logic [rcan_pkg::CFG_W-1:0]           cfg_data
);
  import rcan_pkg::*;

  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ADDR_W = 2 * IDX_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0]          state;
  logic [CFG_W-1:0]    canvas_width;
  logic [CFG_W-1:0]    canvas_height;
  logic [CHAR_W-1:0]   background_char;
  logic [CMP_W-1:0]    width_eff;
  logic [CMP_W-1:0]    height_eff;

  sweep_cmd_t          sw_cmd;
  sweep_stat_t         sw_stat;
  logic signed [COORD_W-1:0] radius;

  logic [STATUS_W-1:0] res_status;
  logic [CHAR_W-1:0]   res_pix;
  logic [STATUS_W-1:0] out_status;
  logic [CHAR_W-1:0]   out_pix;

  logic                      in_acc;
  logic [CMD_W-1:0]          in_cmd;
  logic signed [COORD_W-1:0] in_cx;
  logic signed [COORD_W-1:0] in_cy;
  logic signed [COORD_W-1:0] in_r;
  logic [CHAR_W-1:0]         in_shape;
  logic [CHAR_W-1:0]         in_paint;
  logic [CMP_W-1:0]          in_col;
  logic [CMP_W-1:0]          in_row;
  logic                      in_bad;
  logic                      in_inside;

  logic signed [INNER_W-1:0] inner;
  logic signed [RSQ_W-1:0]   r_wide;
  logic signed [RSQ_W-1:0]   inner_wide;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [7:0]          rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [7:0]          wr_data;
  logic                out_free;

  // Unpack the input transaction
  assign in_cmd   = s_axis_tuser;
  assign in_cx    = s_axis_tdata[IN_CX_LSB +: COORD_W];
  assign in_cy    = s_axis_tdata[IN_CY_LSB +: COORD_W];
  assign in_r     = s_axis_tdata[IN_R_LSB +: COORD_W];
  assign in_shape = s_axis_tdata[IN_SHAPE_LSB +: CHAR_W];
  assign in_paint = s_axis_tdata[IN_PAINT_LSB +: CHAR_W];
  assign in_col   = CMP_W'(s_axis_tdata[IN_COL_LSB +: PIXIDX_W]);
  assign in_row   = CMP_W'(s_axis_tdata[IN_ROW_LSB +: PIXIDX_W]);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_bad        = ((in_shape != SHAPE_FILLED) && (in_shape != SHAPE_RING))
                         || (in_r <= 0);
  assign in_inside     = (in_col < width_eff) && (in_row < height_eff);

  // Clamp the size registers to the store
  assign width_eff  = (CMP_W'(canvas_width) > CMP_W'(MAX_SIDE)) ?
                      CMP_W'(MAX_SIDE) : CMP_W'(canvas_width);
  assign height_eff = (CMP_W'(canvas_height) > CMP_W'(MAX_SIDE)) ?
                      CMP_W'(MAX_SIDE) : CMP_W'(canvas_height);

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= RST_WIDTH;
      canvas_height   <= RST_HEIGHT;
      background_char <= RST_BGCHAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  canvas_width    <= cfg_data;
        REG_HEIGHT: canvas_height   <= cfg_data;
        REG_BGCHAR: background_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel read issued straight from the accepted transaction
  assign rd_en   = in_acc && (in_cmd == CMD_READ) && in_inside;
  assign rd_addr = {in_row[IDX_W-1:0], in_col[IDX_W-1:0]};

  // Radius bounds for the ring test
  assign inner      = INNER_W'(radius) - (INNER_W'(1) << FRAC_BITS);
  assign r_wide     = RSQ_W'(radius);
  assign inner_wide = RSQ_W'(inner);

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Command sequencer; latch command operands and the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sw_cmd.start <= 1'b0;
    end else begin
      sw_cmd.start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_cmd)
              CMD_CLEAR: begin
                sw_cmd.start <= 1'b1;
                state        <= ST_SWEEP;
              end
              CMD_DRAW:  state <= in_bad ? ST_RESP : ST_SETUP;
              CMD_READ:  state <= in_inside ? ST_RDWAIT : ST_RESP;
              default:   state <= ST_RESP;
            endcase
          end
        end
        ST_SETUP: begin
          sw_cmd.start <= 1'b1;
          state        <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (sw_stat.done) begin
            state <= ST_RESP;
          end
        end
        ST_RDWAIT: state <= ST_RESP;
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (in_acc) begin
        sw_cmd.clear_mode <= (in_cmd == CMD_CLEAR);
        sw_cmd.ring       <= (in_shape == SHAPE_RING);
        sw_cmd.fill_char  <= (in_cmd == CMD_CLEAR) ? background_char : in_paint;
        sw_cmd.cx         <= in_cx;
        sw_cmd.cy         <= in_cy;
        radius            <= in_r;
        res_pix           <= '0;
        res_status        <= STATUS_OK;
        if ((in_cmd == CMD_DRAW) && in_bad) begin
          res_status <= STATUS_BAD_CIR;
        end else if ((in_cmd == CMD_READ) && !in_inside) begin
          res_status <= STATUS_OUTSIDE;
        end
      end
      if (state == ST_SETUP) begin
        sw_cmd.rsq      <= $unsigned(r_wide * r_wide);
        sw_cmd.inner_sq <= $unsigned(inner_wide * inner_wide);
        sw_cmd.ring_all <= inner[INNER_W-1];
      end
      if (state == ST_RDWAIT) begin
        res_pix <= rd_data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_RESP) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESP) && out_free) begin
      out_status <= res_status;
      out_pix    <= res_pix;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), out_pix, out_status};

  rcan_sweep #(
    .FRAC_BITS (FRAC_BITS),
    .IDX_W     (IDX_W),
    .CMP_W     (CMP_W)
  ) u_sweep (
    .clk        (clk),
    .rst        (rst),
    .cmd        (sw_cmd),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .stat       (sw_stat),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  rcan_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  a_sweep_only_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sw_stat.running |-> (state == ST_SWEEP))
    else $error("sweep running outside the sweep state");

  a_read_before_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDWAIT) |-> $past(rd_en))
    else $error("read wait without a read");

  a_start_enters_sweep: assert property (@(posedge clk) disable iff (rst)
    sw_cmd.start |-> (state == ST_SWEEP) && !sw_stat.running)
    else $error("sweep start out of sequence");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("canvas read and write overlap");
`endif

endmodule

// ===== test/rcan_canvas_checker.sv =====
// ----------------------------------------------------------------------------
// rcan_canvas_checker
// Watches the command, result and register channels of the circle raster
// canvas. Keeps its own copy of the canvas and the size registers, works out
// the status and pixel character of every accepted command, and compares each
// result transaction with the oldest pending prediction.
// ----------------------------------------------------------------------------
module rcan_canvas_checker #(
  parameter int MAX_SIDE  = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [rcan_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [rcan_pkg::CMD_W-1:0]       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [rcan_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rcan_pkg::CFGIDX_W-1:0]    cfg_index,
  input  logic [rcan_pkg::CFG_W-1:0]       cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import rcan_pkg::*;

  // Result fields, status in the lowest bits
  typedef struct packed {
    logic [CHAR_W-1:0]   pixel_char;
    logic [STATUS_W-1:0] status;
  } canvas_result_t;

  canvas_result_t    expected_results[$];
  logic [CHAR_W-1:0] canvas_img[MAX_SIDE*MAX_SIDE];
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  logic [CHAR_W-1:0] bg_reg;

  // Clamp an oversized size register to the canvas side
  function automatic int side_used(logic [CFG_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  // Exact squared-distance test of one pixel against the circle
  function automatic bit pixel_hit(longint cx, longint cy, longint rad, bit ring,
                                   int x, int y);
    longint one, dx, dy, d2, inner;
    one = longint'(1) << FRAC_BITS;
    dx  = cx - longint'(x) * one;
    dy  = cy - longint'(y) * one;
    d2  = dx * dx + dy * dy;
    if (d2 > rad * rad) return 1'b0;
    if (!ring) return 1'b1;
    inner = rad - one;
    // a ring thinner than one pixel keeps the whole disc
    if (inner < 0) return 1'b1;
    return d2 > inner * inner;
  endfunction

  // Apply one command to the canvas copy and queue its result
  task automatic apply_command(input logic [CMD_W-1:0] cmd,
                               input logic [IN_TDATA_W-1:0] data);
    canvas_result_t              res;
    int                          w, h, col, row;
    logic signed [COORD_W-1:0]   cx, cy, rad;
    logic [CHAR_W-1:0]           shape, paint;
    res   = '0;
    w     = side_used(width_reg);
    h     = side_used(height_reg);
    cx    = data[IN_CX_LSB +: COORD_W];
    cy    = data[IN_CY_LSB +: COORD_W];
    rad   = data[IN_R_LSB +: COORD_W];
    shape = data[IN_SHAPE_LSB +: CHAR_W];
    paint = data[IN_PAINT_LSB +: CHAR_W];
    col   = int'(data[IN_COL_LSB +: PIXIDX_W]);
    row   = int'(data[IN_ROW_LSB +: PIXIDX_W]);
    case (cmd)
      CMD_CLEAR: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            canvas_img[y*MAX_SIDE + x] = bg_reg;
      end
      CMD_DRAW: begin
        if ((shape != SHAPE_FILLED && shape != SHAPE_RING) || rad <= 0) begin
          res.status = STATUS_BAD_CIR;
        end else begin
          for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
              if (pixel_hit(longint'(cx), longint'(cy), longint'(rad),
                            shape == SHAPE_RING, x, y))
                canvas_img[y*MAX_SIDE + x] = paint;
        end
      end
      CMD_READ: begin
        if (col >= w || row >= h)
          res.status = STATUS_OUTSIDE;
        else
          res.pixel_char = canvas_img[row*MAX_SIDE + col];
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endtask

  // Track registers, predict on command transactions, check result transactions
  always @(posedge clk) begin
    canvas_result_t got, want;
    if (rst) begin
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      bg_reg     = RST_BGCHAR;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  width_reg  = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          REG_BGCHAR: bg_reg     = cfg_data[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_command(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_USED_W-1:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d pixel_char %0d",
                 got.status, got.pixel_char);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.pixel_char !== want.pixel_char) begin
            $error("pixel_char: expected %0d, got %0d",
                   want.pixel_char, got.pixel_char);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/tb_circle_raster_canvas.sv =====
// ----------------------------------------------------------------------------
// tb_circle_raster_canvas
// Drives clear, draw and read commands into the circle raster canvas with
// random gaps on both stream sides. Starts with directed circles, radius and
// canvas-size corner cases, then random phases on small canvases, one full
// size canvas, and a closing stretch without any idling.
// ----------------------------------------------------------------------------
module tb_circle_raster_canvas;
  import rcan_pkg::*;

  localparam int     MAX_SIDE    = 512;
  localparam int     FRAC_BITS   = 8;
  localparam int     ONE         = 1 << FRAC_BITS;
  localparam int     HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 4_000_000;

  // Codes the block accepts but the package does not name
  localparam logic [CMD_W-1:0]    CMD_SPARE = 2'd3;
  localparam logic [CFGIDX_W-1:0] REG_SPARE = 2'd3;

  // Command fields, row in the top bits, center_x in the lowest
  typedef struct packed {
    logic [PIXIDX_W-1:0] row;
    logic [PIXIDX_W-1:0] col;
    logic [CHAR_W-1:0]   paint;
    logic [CHAR_W-1:0]   shape;
    logic [COORD_W-1:0]  r;
    logic [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]  cx;
  } canvas_req_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFGIDX_W-1:0]    cfg_index     = '0;
  logic [CFG_W-1:0]       cfg_data      = '0;

  int     fail_count;
  int     pending;
  longint cycles    = 0;
  bit     idle_on   = 1'b1;
  bit     hold_req  = 1'b0;
  int     cols_used = 300;
  int     rows_used = 300;

  circle_raster_canvas #(
    .MAX_SIDE (MAX_SIDE),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rcan_canvas_checker #(
    .MAX_SIDE (MAX_SIDE),
    .FRAC_BITS(FRAC_BITS)
  ) chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 15);
        m_axis_tready <= 1'b0;
      end else begin
        n = $urandom_range(1, 20);
        m_axis_tready <= 1'b1;
      end
      repeat (n) @(negedge clk);
    end
  end

  // Every field random; callers override what the command needs
  function automatic canvas_req_t rand_req();
    canvas_req_t req;
    req.cx    = COORD_W'($urandom);
    req.cy    = COORD_W'($urandom);
    req.r     = COORD_W'($urandom);
    req.shape = CHAR_W'($urandom);
    req.paint = CHAR_W'($urandom);
    req.col   = PIXIDX_W'($urandom);
    req.row   = PIXIDX_W'($urandom);
    return req;
  endfunction

  // Offer one command transaction, with an occasional gap before it
  task automatic send(input logic [CMD_W-1:0] cmd, input canvas_req_t req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_TDATA_W'(req);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic clear_canvas();
    send(CMD_CLEAR, rand_req());
  endtask

  task automatic read_px(input int col, input int row);
    canvas_req_t req;
    req     = rand_req();
    req.col = PIXIDX_W'(col);
    req.row = PIXIDX_W'(row);
    send(CMD_READ, req);
  endtask

  task automatic draw_circle(input logic [CHAR_W-1:0] shape, input int cx, input int cy,
                             input int r, input logic [CHAR_W-1:0] paint);
    canvas_req_t req;
    req       = rand_req();
    req.shape = shape;
    req.cx    = COORD_W'(cx);
    req.cy    = COORD_W'(cy);
    req.r     = COORD_W'(r);
    req.paint = paint;
    send(CMD_DRAW, req);
  endtask

  // Stop offering, drain every pending result, let the block go quiet
  task automatic settle();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFGIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_canvas(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] bg);
    settle();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_BGCHAR, bg);
    cols_used = (w > MAX_SIDE) ? MAX_SIDE : int'(w);
    rows_used = (h > MAX_SIDE) ? MAX_SIDE : int'(h);
  endtask

  // Small random canvas: clear first, then mostly sane circles and reads
  task automatic random_phase(input int n, input bit hold);
    canvas_req_t req;
    int          kind, span;
    set_canvas(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 40)),
               CFG_W'($urandom));
    clear_canvas();
    if (hold) begin
      // let the clear finish, then stall the result side and keep offering
      // reads until the input backs up
      settle();
      hold_req = 1'b1;
      wait (!hold_req);
      repeat (8) read_px($urandom_range(0, cols_used-1), $urandom_range(0, rows_used-1));
    end
    span = (cols_used > rows_used) ? cols_used : rows_used;
    repeat (n) begin
      req  = rand_req();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        req.cx    = COORD_W'(int'($urandom_range(0, (cols_used+8)*ONE)) - 4*ONE);
        req.cy    = COORD_W'(int'($urandom_range(0, (rows_used+8)*ONE)) - 4*ONE);
        req.r     = COORD_W'($urandom_range(1, (span/2 + 3)*ONE));
        req.shape = $urandom_range(0, 1) ? SHAPE_RING : SHAPE_FILLED;
        send(CMD_DRAW, req);
      end else if (kind < 80) begin
        req.col = PIXIDX_W'($urandom_range(0, cols_used-1));
        req.row = PIXIDX_W'($urandom_range(0, rows_used-1));
        send(CMD_READ, req);
      end else if (kind < 86) begin
        send(CMD_READ, req);
      end else if (kind < 94) begin
        // raw fields: huge, negative or zero radius, odd shape bytes
        if ($urandom_range(0, 1)) req.shape = $urandom_range(0, 1) ? SHAPE_RING : SHAPE_FILLED;
        if ($urandom_range(0, 3) == 0) req.r = COORD_W'(-int'($urandom_range(0, 3)));
        send(CMD_DRAW, req);
      end else if (kind < 97) begin
        send(CMD_SPARE, req);
      end else begin
        send(CMD_CLEAR, req);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Registers at their reset values
    clear_canvas();
    read_px(299, 299);
    read_px(300, 5);
    read_px(5, 300);

    // Directed circles on a small canvas
    set_canvas(10'd20, 10'd16, 10'("."));
    clear_canvas();
    read_px(0, 0);
    read_px(19, 15);
    read_px(20, 0);
    read_px(0, 16);
    read_px(511, 511);
    draw_circle(SHAPE_FILLED, 10*ONE, 8*ONE, 5*ONE, "#");
    draw_circle(SHAPE_RING, 10*ONE + ONE/2, 8*ONE, 3*ONE + ONE/2, "o");
    // ring thinner than a pixel, and ring of radius exactly one
    draw_circle(SHAPE_RING, 3*ONE, 3*ONE, ONE/2, "+");
    draw_circle(SHAPE_RING, 16*ONE, 12*ONE, ONE, "*");
    draw_circle(SHAPE_FILLED, ONE, 14*ONE, 1, "x");
    // bad radius and bad shape leave the canvas alone
    draw_circle(SHAPE_FILLED, 5*ONE, 5*ONE, 0, "!");
    draw_circle(SHAPE_RING, 5*ONE, 5*ONE, -1, "!");
    draw_circle(SHAPE_FILLED, 5*ONE, 5*ONE, -524288, "!");
    draw_circle(8'h00, 5*ONE, 5*ONE, 4*ONE, "!");
    draw_circle(8'hFF, 5*ONE, 5*ONE, 4*ONE, "!");
    draw_circle(8'h42, 5*ONE, 5*ONE, 4*ONE, "!");
    draw_circle(SHAPE_FILLED, -524288, 524287, 524287, "@");
    send(CMD_SPARE, rand_req());
    read_px(10, 8);
    read_px(13, 8);
    read_px(3, 3);
    read_px(16, 12);
    read_px(1, 14);
    read_px(5, 5);
    read_px(0, 15);

    // Empty canvas in either direction
    set_canvas(10'd0, 10'd16, 10'h3FF);
    clear_canvas();
    draw_circle(SHAPE_FILLED, 0, 0, 4*ONE, "Z");
    read_px(0, 0);
    set_canvas(10'd5, 10'd0, 10'h155);
    clear_canvas();
    read_px(0, 0);

    // Single pixel canvas
    set_canvas(10'd1, 10'd1, 10'h2AA);
    clear_canvas();
    read_px(0, 0);
    draw_circle(SHAPE_RING, 0, 0, ONE/2, "r");
    read_px(0, 0);
    read_px(1, 0);

    // Oversized registers clamp to the canvas side
    set_canvas(10'h3FF, 10'd2, 10'h3FF);
    clear_canvas();
    draw_circle(SHAPE_RING, 400*ONE, ONE, 2*ONE, "w");
    read_px(511, 1);
    read_px(398, 1);
    read_px(300, 0);
    set_canvas(10'd3, 10'h3FF, 10'h000);
    clear_canvas();
    draw_circle(SHAPE_FILLED, ONE, 300*ONE, 3*ONE, "h");
    read_px(2, 511);
    read_px(1, 300);
    read_px(0, 200);
    settle();
    cfg_write(REG_SPARE, CFG_W'($urandom));

    // Random phases, one with a long result hold-off
    for (int p = 0; p < 4; p++)
      random_phase(5, p == 2);

    // Full size canvas
    set_canvas(10'd512, 10'h3FF, CFG_W'($urandom));
    clear_canvas();
    draw_circle(SHAPE_RING, 255*ONE + ONE/2, 256*ONE, 200*ONE, "O");
    read_px(511, 511);
    read_px(256, 256);
    read_px(256, 56);
    read_px(55, 256);
    read_px(0, 511);

    // Closing stretch without any idling
    idle_on = 1'b0;
    random_phase(10, 1'b0);

    settle();
    repeat (16) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
